[rtl/ufe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ufe_pkg - shared types and constants for the union-find engine
// Node and size widths, request and result records, sequencer states.
// ----------------------------------------------------------------------------
package ufe_pkg;

  localparam int unsigned NODE_W = 10;
  localparam int unsigned NODES  = 1 << NODE_W;
  localparam int unsigned SIZE_W = NODE_W + 1;
  localparam int unsigned LINK_W = NODE_W + 1;  // root flag on top of the index

  localparam int unsigned IN_DATA_W  = 24;  // two node indexes, padded to bytes
  localparam int unsigned OUT_DATA_W = 24;  // root, merged, size, padded

  localparam logic [LINK_W-1:0] ROOT_LINK = {1'b1, {NODE_W{1'b0}}};
  localparam logic [SIZE_W-1:0] ONE_SIZE  = {{(SIZE_W-1){1'b0}}, 1'b1};
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

  typedef enum logic {
    OP_UNION = 1'b0,
    OP_FIND  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_CNT_RA,
    ST_CNT_RB,
    ST_MERGE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] root_node;
    logic              merged;
    logic [SIZE_W-1:0] set_size;
  } res_t;

endpackage
`default_nettype wire

[rtl/ufe_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ufe_core - union-find sequencer and link/size tables
// Walks parent links one hop a cycle, compresses the path, merges by size.
// ----------------------------------------------------------------------------
module ufe_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         req_valid_i,
  output logic              req_ready_o,
  input  wire ufe_pkg::req_t req_i,
  output logic              res_valid_o,
  input  wire logic         res_ready_i,
  output ufe_pkg::res_t     res_o
);

  ufe_pkg::state_e state_q, state_d;

  logic [ufe_pkg::NODE_W-1:0] clr_q, clr_d;
  logic [ufe_pkg::NODE_W-1:0] cur_q, cur_d;
  logic [ufe_pkg::NODE_W-1:0] walk_q, walk_d;
  logic [ufe_pkg::NODE_W-1:0] ra_q, ra_d;
  logic [ufe_pkg::NODE_W-1:0] rb_q, rb_d;
  logic [ufe_pkg::NODE_W-1:0] b_q, b_d;
  logic [ufe_pkg::SIZE_W-1:0] ca_q, ca_d;
  ufe_pkg::op_e               op_q, op_d;
  logic                       phase_q, phase_d;
  ufe_pkg::res_t              res_q, res_d;

  // Link table: root flag in the top bit, parent index below
  logic [ufe_pkg::LINK_W-1:0] link_mem [ufe_pkg::NODES];
  logic [ufe_pkg::NODE_W-1:0] link_addr;
  logic                       link_we;
  logic [ufe_pkg::LINK_W-1:0] link_wdata;
  logic [ufe_pkg::LINK_W-1:0] link_rdata;

  // Size table, meaningful at roots only
  logic [ufe_pkg::SIZE_W-1:0] size_mem [ufe_pkg::NODES];
  logic [ufe_pkg::NODE_W-1:0] size_addr;
  logic                       size_we;
  logic [ufe_pkg::SIZE_W-1:0] size_wdata;
  logic [ufe_pkg::SIZE_W-1:0] size_rdata;

  // Shared equality compare, and the size adder/compare used in the merge
  logic [ufe_pkg::NODE_W-1:0] cmp_x, cmp_y;
  logic                       cmp_eq;
  logic [ufe_pkg::SIZE_W-1:0] size_sum;
  logic                       size_ge;
  logic                       link_is_root;
  logic [ufe_pkg::NODE_W-1:0] link_idx;

  assign link_is_root = link_rdata[ufe_pkg::NODE_W];
  assign link_idx     = link_rdata[ufe_pkg::NODE_W-1:0];

  always_comb begin
    if (state_q == ufe_pkg::ST_CNT_RB) begin
      cmp_x = ra_q;
      cmp_y = rb_q;
    end else begin
      cmp_x = walk_q;
      cmp_y = cur_q;
    end
  end

  assign cmp_eq   = (cmp_x == cmp_y);
  assign size_sum = ca_q + size_rdata;
  assign size_ge  = (ca_q >= size_rdata);

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_addr] <= link_wdata;
    end
    link_rdata <= link_mem[link_addr];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_addr] <= size_wdata;
    end
    size_rdata <= size_mem[size_addr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ufe_pkg::ST_CLEAR: begin
        if (clr_q == ufe_pkg::LAST_NODE) state_d = ufe_pkg::ST_IDLE;
      end
      ufe_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = ufe_pkg::ST_WALK;
      end
      ufe_pkg::ST_WALK: begin
        if (link_is_root) state_d = ufe_pkg::ST_COMP_RD;
      end
      ufe_pkg::ST_COMP_RD: begin
        if (!cmp_eq) begin
          state_d = ufe_pkg::ST_COMP_WR;
        end else if (!phase_q && op_q == ufe_pkg::OP_UNION) begin
          state_d = ufe_pkg::ST_WALK;
        end else begin
          state_d = ufe_pkg::ST_CNT_RA;
        end
      end
      ufe_pkg::ST_COMP_WR: state_d = ufe_pkg::ST_COMP_RD;
      ufe_pkg::ST_CNT_RA:  state_d = ufe_pkg::ST_CNT_RB;
      ufe_pkg::ST_CNT_RB: begin
        if (op_q == ufe_pkg::OP_FIND || cmp_eq) begin
          state_d = ufe_pkg::ST_FINISH;
        end else begin
          state_d = ufe_pkg::ST_MERGE;
        end
      end
      ufe_pkg::ST_MERGE: state_d = ufe_pkg::ST_FINISH;
      ufe_pkg::ST_FINISH: begin
        if (res_ready_i) state_d = ufe_pkg::ST_IDLE;
      end
      default: state_d = ufe_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and table controls
  always_comb begin
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    link_addr   = cur_q;
    link_we     = 1'b0;
    link_wdata  = ufe_pkg::ROOT_LINK;
    size_addr   = ra_q;
    size_we     = 1'b0;
    size_wdata  = ufe_pkg::ONE_SIZE;
    clr_d       = clr_q;
    cur_d       = cur_q;
    walk_d      = walk_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    b_d         = b_q;
    ca_d        = ca_q;
    op_d        = op_q;
    phase_d     = phase_q;
    res_d       = res_q;
    case (state_q)
      ufe_pkg::ST_CLEAR: begin
        // Sweep both tables: every node its own root of size one
        link_addr = clr_q;
        link_we   = 1'b1;
        size_addr = clr_q;
        size_we   = 1'b1;
        clr_d     = clr_q + 1'b1;
      end
      ufe_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        link_addr   = req_i.first_node;
        if (req_valid_i) begin
          op_d    = req_i.op;
          b_d     = req_i.second_node;
          cur_d   = req_i.first_node;
          walk_d  = req_i.first_node;
          phase_d = 1'b0;
        end
      end
      ufe_pkg::ST_WALK: begin
        // Advance one hop a cycle until the root flag shows
        if (!link_is_root) begin
          cur_d     = link_idx;
          link_addr = link_idx;
        end
      end
      ufe_pkg::ST_COMP_RD: begin
        link_addr = walk_q;
        if (cmp_eq) begin
          if (!phase_q) begin
            ra_d = cur_q;
          end else begin
            rb_d = cur_q;
          end
          if (!phase_q && op_q == ufe_pkg::OP_UNION) begin
            phase_d   = 1'b1;
            cur_d     = b_q;
            walk_d    = b_q;
            link_addr = b_q;
          end
        end
      end
      ufe_pkg::ST_COMP_WR: begin
        // Point the path node straight at the root, move to its old parent
        link_addr  = walk_q;
        link_we    = 1'b1;
        link_wdata = {1'b0, cur_q};
        walk_d     = link_idx;
      end
      ufe_pkg::ST_CNT_RA: begin
        size_addr = ra_q;
      end
      ufe_pkg::ST_CNT_RB: begin
        ca_d      = size_rdata;
        size_addr = rb_q;
        if (op_q == ufe_pkg::OP_FIND || cmp_eq) begin
          res_d.root_node = ra_q;
          res_d.merged    = 1'b0;
          res_d.set_size  = size_rdata;
        end
      end
      ufe_pkg::ST_MERGE: begin
        // Larger or equal set absorbs; ties go to the first root
        link_we    = 1'b1;
        size_we    = 1'b1;
        size_wdata = size_sum;
        res_d.merged   = 1'b1;
        res_d.set_size = size_sum;
        if (size_ge) begin
          link_addr       = rb_q;
          link_wdata      = {1'b0, ra_q};
          size_addr       = ra_q;
          res_d.root_node = ra_q;
        end else begin
          link_addr       = ra_q;
          link_wdata      = {1'b0, rb_q};
          size_addr       = rb_q;
          res_d.root_node = rb_q;
        end
      end
      ufe_pkg::ST_FINISH: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ufe_pkg::ST_CLEAR;
      clr_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    walk_q <= walk_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    b_q    <= b_d;
    ca_q   <= ca_d;
    op_q   <= op_d;
    res_q  <= res_d;
  end

endmodule
`default_nettype wire

[rtl/union_find_engine_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_engine_top - disjoint-set engine, path compression, union by size
// Takes union or find requests on a stream and returns one result per request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata: first_node, second_node
//                                           tuser: operation (0 union, 1 find)
//  m_axis   out  m_axis_tvalid/tready       tdata: root_node, merged, set_size
//
//  Timing: a find walks h hops to the root, then rewrites the c nodes on its
//  path with a read and a write each, then reads the root's size and hands
//  its result to m_axis. A union repeats the walk and the compression for
//  the second node and adds a merge step when the sets differ. The
//  single-port link table, read once per hop and per path node and written
//  once per compressed node, sets the pace.
//  Reset: a clearing pass over all 1024 nodes marks every node as a root of
//  size one; no request is taken until it ends.
//  Stalls: the result register holds a finished result while the next request
//  is already taken; the engine waits at its end only if that result is still
//  unclaimed.
// ----------------------------------------------------------------------------
module union_find_engine_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [9:0] first_node, [19:10] second_node, [23:20] zero
  input  wire logic [ufe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [9:0] root_node, [10] merged, [21:11] set_size, [23:22] zero
  output logic [ufe_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  ufe_pkg::req_t req;
  ufe_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  logic          out_valid_q, out_valid_d;
  ufe_pkg::res_t out_q;

  // Unpack the request: node indexes from tdata, the operation from tuser
  assign req.op          = ufe_pkg::op_e'(s_axis_tuser);
  assign req.first_node  = s_axis_tdata[ufe_pkg::NODE_W-1:0];
  assign req.second_node = s_axis_tdata[2*ufe_pkg::NODE_W-1:ufe_pkg::NODE_W];

  ufe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The result register is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until taken; load a fresh result when the slot frees
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ufe_pkg::OUT_DATA_W - ufe_pkg::NODE_W - 1
                            - ufe_pkg::SIZE_W){1'b0}},
                          out_q.set_size, out_q.merged, out_q.root_node};

endmodule
`default_nettype wire
